// ===== sv/lc3ie_pkg.sv =====
// ----------------------------------------------------------------------------
// lc3ie_pkg: shared definitions for the LC-3 execute block
// Opcodes, item action codes, condition codes, sequencer states and helpers.
// ----------------------------------------------------------------------------
package lc3ie_pkg;

  localparam int ADDR_BITS_DEF = 16;
  localparam int RF_DEPTH      = 8;
  localparam int WORD_W        = 16;

  // item actions
  localparam logic [1:0] ACT_EXEC  = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_SETPC = 2'd2;

  // opcodes, bits 15..12
  localparam logic [3:0] OP_ADD = 4'd1;
  localparam logic [3:0] OP_LD  = 4'd2;
  localparam logic [3:0] OP_ST  = 4'd3;
  localparam logic [3:0] OP_JSR = 4'd4;
  localparam logic [3:0] OP_AND = 4'd5;
  localparam logic [3:0] OP_LDR = 4'd6;
  localparam logic [3:0] OP_NOT = 4'd9;
  localparam logic [3:0] OP_LDI = 4'd10;
  localparam logic [3:0] OP_JMP = 4'd12;
  localparam logic [3:0] OP_LEA = 4'd14;

  // condition codes
  localparam logic [1:0] CC_NEG  = 2'd0;
  localparam logic [1:0] CC_ZERO = 2'd1;
  localparam logic [1:0] CC_POS  = 2'd2;

  localparam logic [2:0] LINK_REG = 3'd7;

  // result word layout
  localparam int OUT_TDATA_W = 72;
  localparam int CC_LO       = 16;
  localparam int RIDX_LO     = 18;
  localparam int RVAL_HI     = 36;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEC,
    ST_EX,
    ST_MEM
  } state_t;

  function automatic logic [1:0] cc_of(input logic [15:0] v);
    if (v == 16'd0) begin
      return CC_ZERO;
    end
    return v[15] ? CC_NEG : CC_POS;
  endfunction

endpackage

// ===== sv/lc3ie_ram.sv =====
// ----------------------------------------------------------------------------
// lc3ie_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module lc3ie_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lc3_instruction_execute.sv =====
// ----------------------------------------------------------------------------
// lc3_instruction_execute: LC-3 instruction execute unit
// Runs one LC-3 instruction, memory load word or PC set per input word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one word per item. in_tuser carries the action
//   (execute, load memory word, set PC), in_tdata the instruction, the load
//   address and the load data. Output channel (out_*): one result word per
//   item, in order: PC, condition code, register write and store report.
//   Sequencer states from accept to result valid:
//     load word / set PC / unused action ........ DEC
//     ADD AND NOT LD LEA ST JMP JSR, others ..... DEC, EX
//     LDR LDI ................................... DEC, EX, MEM
//   The sequencer takes the next word in the cycle the current one retires,
//   so a new item is taken only once the current one is through; the EX
//   and MEM states wait on the registered reads of the register file and
//   the main memory port (LDI chains two main memory reads).
//   The result sits in an output register; a new item is taken and worked
//   on while that result waits. When out_tready stays low the item at
//   retirement holds and in_tready drops.
//   Reset clears PC to zero, condition to Z and all registers to zero
//   (valid bits mask the register RAM). Main memory is not cleared; words
//   must be loaded before they are read.
// ----------------------------------------------------------------------------
module lc3_instruction_execute #(
  parameter int ADDR_BITS = lc3ie_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input word
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // instruction[15:0], load_address[31:16], load_data[47:32]
  input  logic [1:0]  in_tuser,   // action[1:0]
  // result word
  output logic        out_tvalid,
  input  logic        out_tready,
  // pc_now[15:0], cond_code[17:16], reg_index[20:18], reg_value[36:21],
  // mem_address[52:37], mem_value[68:53], zero fill[71:69]
  output logic [71:0] out_tdata,
  output logic [1:0]  out_tuser   // reg_written[0], mem_written[1]
);

  localparam int MEM_DEPTH = 1 << ADDR_BITS;

  // ---- state ----
  lc3ie_pkg::state_t state_r, state_nxt;
  logic [15:0] pc_r;
  logic [1:0]  cc_r;
  logic [lc3ie_pkg::RF_DEPTH-1:0] rf_valid_r;

  // current item (payload)
  logic [1:0]  act_r;
  logic [15:0] ins_r;
  logic [15:0] laddr_r;
  logic [15:0] ldata_r;
  logic [ADDR_BITS-1:0] mem2_addr_r;

  // output register
  logic        out_valid_r;
  logic [71:0] out_data_r;
  logic [1:0]  out_user_r;

  // ---- decode ----
  logic [3:0] op;
  logic [2:0] dr, sr, rfb_addr;
  assign op       = ins_r[15:12];
  assign dr       = ins_r[11:9];
  assign sr       = ins_r[8:6];
  assign rfb_addr = (op == lc3ie_pkg::OP_ST) ? dr : ins_r[2:0];

  // ---- register file: two copies, one per read port ----
  logic        rf_we;
  logic [2:0]  rf_widx;
  logic [15:0] rf_wdata;
  logic [15:0] rfa_rdata, rfb_rdata;

  lc3ie_ram #(.WIDTH(lc3ie_pkg::WORD_W), .DEPTH(lc3ie_pkg::RF_DEPTH)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(rf_widx), .wdata(rf_wdata),
    .raddr(sr), .rdata(rfa_rdata)
  );

  lc3ie_ram #(.WIDTH(lc3ie_pkg::WORD_W), .DEPTH(lc3ie_pkg::RF_DEPTH)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(rf_widx), .wdata(rf_wdata),
    .raddr(rfb_addr), .rdata(rfb_rdata)
  );

  // never-written registers read as zero
  logic [15:0] srv, bv;
  assign srv = rf_valid_r[sr]       ? rfa_rdata : 16'd0;
  assign bv  = rf_valid_r[rfb_addr] ? rfb_rdata : 16'd0;

  // ---- main memory ----
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
  logic [15:0]          mem_wdata, mem_rdata;

  lc3ie_ram #(.WIDTH(lc3ie_pkg::WORD_W), .DEPTH(MEM_DEPTH)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // ---- address arithmetic ----
  logic [15:0] pc_inc, pc_off9, pc_off11, ldr_addr;
  assign pc_inc   = pc_r + 16'd1;
  assign pc_off9  = pc_inc + {{7{ins_r[8]}}, ins_r[8:0]};
  assign pc_off11 = pc_inc + {{5{ins_r[10]}}, ins_r[10:0]};
  assign ldr_addr = srv + {{10{ins_r[5]}}, ins_r[5:0]};

  // read address stays put while a state stalls so the registered data holds
  always_comb begin
    unique case (state_r)
      lc3ie_pkg::ST_MEM: mem_raddr = mem2_addr_r;
      lc3ie_pkg::ST_EX: begin
        if (op == lc3ie_pkg::OP_LDI) begin
          mem_raddr = mem_rdata[ADDR_BITS-1:0];
        end else if (op == lc3ie_pkg::OP_LDR) begin
          mem_raddr = ldr_addr[ADDR_BITS-1:0];
        end else begin
          mem_raddr = pc_off9[ADDR_BITS-1:0];
        end
      end
      default: mem_raddr = pc_off9[ADDR_BITS-1:0];
    endcase
  end

  // ---- sequencer ----
  logic        out_free, fin;
  logic        rw, mw, set_cc, load_wr;
  logic [2:0]  ridx;
  logic [15:0] rval, maddr, mval, new_pc;
  logic [1:0]  res_cc;
  logic [15:0] opnd;

  assign out_free = !out_valid_r || out_tready;
  assign opnd     = ins_r[5] ? {{11{ins_r[4]}}, ins_r[4:0]} : bv;

  always_comb begin
    state_nxt = state_r;
    fin       = 1'b0;
    rw        = 1'b0;
    mw        = 1'b0;
    set_cc    = 1'b0;
    load_wr   = 1'b0;
    ridx      = 3'd0;
    rval      = 16'd0;
    maddr     = 16'd0;
    mval      = 16'd0;
    new_pc    = pc_r;

    unique case (state_r)
      lc3ie_pkg::ST_IDLE: ;
      lc3ie_pkg::ST_DEC: begin
        if (act_r == lc3ie_pkg::ACT_EXEC) begin
          state_nxt = lc3ie_pkg::ST_EX;
        end else begin
          fin     = out_free;
          load_wr = (act_r == lc3ie_pkg::ACT_LOAD);
          if (act_r == lc3ie_pkg::ACT_SETPC) begin
            new_pc = ldata_r;
          end
        end
      end
      lc3ie_pkg::ST_EX: begin
        new_pc = pc_inc;
        fin    = out_free;
        unique case (op)
          lc3ie_pkg::OP_ADD: begin
            rw = 1'b1; ridx = dr; set_cc = 1'b1; rval = srv + opnd;
          end
          lc3ie_pkg::OP_AND: begin
            rw = 1'b1; ridx = dr; set_cc = 1'b1; rval = srv & opnd;
          end
          lc3ie_pkg::OP_NOT: begin
            rw = 1'b1; ridx = dr; set_cc = 1'b1; rval = ~srv;
          end
          lc3ie_pkg::OP_LD: begin
            rw = 1'b1; ridx = dr; set_cc = 1'b1; rval = mem_rdata;
          end
          lc3ie_pkg::OP_LEA: begin
            rw = 1'b1; ridx = dr; set_cc = 1'b1; rval = pc_off9;
          end
          lc3ie_pkg::OP_ST: begin
            mw    = 1'b1;
            maddr = 16'(pc_off9[ADDR_BITS-1:0]);
            mval  = bv;
          end
          lc3ie_pkg::OP_JMP: new_pc = srv;
          lc3ie_pkg::OP_JSR: begin
            // base read above; R7 gets the link after
            rw     = 1'b1;
            ridx   = lc3ie_pkg::LINK_REG;
            rval   = pc_inc;
            new_pc = ins_r[11] ? pc_off11 : srv;
          end
          lc3ie_pkg::OP_LDR, lc3ie_pkg::OP_LDI: begin
            fin       = 1'b0;
            state_nxt = lc3ie_pkg::ST_MEM;
          end
          default: ;
        endcase
      end
      lc3ie_pkg::ST_MEM: begin
        new_pc = pc_inc;
        fin    = out_free;
        rw     = 1'b1;
        ridx   = dr;
        set_cc = 1'b1;
        rval   = mem_rdata;
      end
      default: ;
    endcase

    // same condition as in_tready
    if ((state_r == lc3ie_pkg::ST_IDLE) || fin) begin
      state_nxt = in_tvalid ? lc3ie_pkg::ST_DEC : lc3ie_pkg::ST_IDLE;
    end
  end

  assign in_tready = (state_r == lc3ie_pkg::ST_IDLE) || fin;
  assign res_cc    = set_cc ? lc3ie_pkg::cc_of(rval) : cc_r;

  // write ports
  assign rf_we     = fin && rw;
  assign rf_widx   = ridx;
  assign rf_wdata  = rval;
  assign mem_we    = fin && (load_wr || mw);
  assign mem_waddr = load_wr ? laddr_r[ADDR_BITS-1:0] : pc_off9[ADDR_BITS-1:0];
  assign mem_wdata = load_wr ? ldata_r : bv;

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lc3ie_pkg::ST_IDLE;
      pc_r        <= 16'd0;
      cc_r        <= lc3ie_pkg::CC_ZERO;
      rf_valid_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin) begin
        pc_r        <= new_pc;
        cc_r        <= res_cc;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (rf_we) begin
        rf_valid_r[rf_widx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r   <= in_tuser;
      ins_r   <= in_tdata[15:0];
      laddr_r <= in_tdata[31:16];
      ldata_r <= in_tdata[47:32];
    end
    if (state_r == lc3ie_pkg::ST_EX) begin
      mem2_addr_r <= mem_raddr;
    end
    if (fin) begin
      out_data_r <= {3'd0, mval, maddr, rval, ridx, res_cc, new_pc};
      out_user_r <= {mw, rw};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== sv/lc3ie_checker.sv =====
// ----------------------------------------------------------------------------
// lc3ie_checker: port-level checks for the LC-3 execute block
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module lc3ie_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a store never also writes a register
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("register and memory write in one result");

  // condition code is always N, Z or P
  a_cc_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[lc3ie_pkg::CC_LO+1:lc3ie_pkg::CC_LO] != 2'd3)
    else $error("illegal condition code");

  // no register write reports zero index and value
  a_rw_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0]
      |-> out_tdata[lc3ie_pkg::RVAL_HI:lc3ie_pkg::RIDX_LO] == '0)
    else $error("register report without register write");

  // a result only follows an accepted word: none right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind lc3_instruction_execute lc3ie_checker u_lc3ie_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for lc3_instruction_execute
// Feeds LC-3 instruction, memory-load and PC-set words through the input
// stream, predicts every result word with an in-bench execution model and
// compares the output stream field by field under random back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lc3ie_pkg::*;

  localparam int ADDR_BITS = ADDR_BITS_DEF;
  localparam logic [15:0] ADDR_MASK = 16'((32'd1 << ADDR_BITS) - 1);

  // action code the block must treat as a no-op
  localparam logic [1:0] ACT_NONE = 2'd3;

  // opcodes the block leaves unimplemented (PC increment only)
  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_STR  = 4'd7;
  localparam logic [3:0] OP_RTI  = 4'd8;
  localparam logic [3:0] OP_STI  = 4'd11;
  localparam logic [3:0] OP_RSV  = 4'd13;
  localparam logic [3:0] OP_TRAP = 4'd15;

  // implemented opcodes, used to bias random instructions
  localparam logic [3:0] LIVE_OPS [10] = '{OP_ADD, OP_AND, OP_NOT, OP_LD, OP_LDI,
                                           OP_LDR, OP_LEA, OP_ST, OP_JMP, OP_JSR};

  localparam int CYCLE_LIMIT = 400000;

  // one result word, unpacked into its fields
  typedef struct packed {
    logic [15:0] pc;
    logic [1:0]  cc;
    logic        rw;
    logic [2:0]  ridx;
    logic [15:0] rval;
    logic        mw;
    logic [15:0] maddr;
    logic [15:0] mval;
  } result_t;

  localparam result_t NO_RESULT = '0;

  // one directed row; typed rows carry a hand-written expectation
  typedef struct packed {
    logic [1:0]  act;
    logic [15:0] ins;
    logic [15:0] laddr;
    logic [15:0] ldata;
    logic        typed;
    result_t     exp;
  } step_t;

  // Directed walk. PC and register values chain from row to row, so the
  // order matters: every memory read hits a word written earlier.
  localparam int N_DIRECTED = 25;
  localparam step_t DIRECTED [N_DIRECTED] = '{
    // unused action right after reset: reset PC and Z flag, nothing written
    '{ACT_NONE, 16'h0000, 16'h0000, 16'h0000, 1'b1,
      '{16'h0000, CC_ZERO, 1'b0, 3'd0, 16'h0000, 1'b0, 16'h0000, 16'h0000}},
    // PC to its top value
    '{ACT_SETPC, 16'h0000, 16'h0000, 16'hFFFF, 1'b1,
      '{16'hFFFF, CC_ZERO, 1'b0, 3'd0, 16'h0000, 1'b0, 16'h0000, 16'h0000}},
    // ADD R0,R0,#-16 with PC wrapping to zero
    '{ACT_EXEC, {OP_ADD, 3'd0, 3'd0, 1'b1, 5'h10}, 16'h0000, 16'h0000, 1'b1,
      '{16'h0000, CC_NEG, 1'b1, 3'd0, 16'hFFF0, 1'b0, 16'h0000, 16'h0000}},
    '{ACT_EXEC, {OP_ADD, 3'd1, 3'd0, 1'b1, 5'h0F}, 16'h0, 16'h0, 1'b0, NO_RESULT},
    '{ACT_EXEC, {OP_AND, 3'd2, 3'd1, 3'b000, 3'd0}, 16'h0, 16'h0, 1'b0, NO_RESULT},
    '{ACT_EXEC, {OP_AND, 3'd3, 3'd3, 1'b1, 5'h00}, 16'h0, 16'h0, 1'b0, NO_RESULT},
    '{ACT_EXEC, {OP_NOT, 3'd4, 3'd3, 6'h3F}, 16'h0, 16'h0, 1'b0, NO_RESULT},
    '{ACT_EXEC, {OP_ADD, 3'd5, 3'd4, 3'b000, 3'd1}, 16'h0, 16'h0, 1'b0, NO_RESULT},
    // memory words at both address extremes
    '{ACT_LOAD, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, NO_RESULT},
    '{ACT_LOAD, 16'h0000, 16'hFFFF, 16'h0000, 1'b0, NO_RESULT},
    '{ACT_SETPC, 16'h0000, 16'h0000, 16'h0100, 1'b0, NO_RESULT},
    // ST max offset, LD reads it back, LEA min offset
    '{ACT_EXEC, {OP_ST, 3'd4, 9'h0FF}, 16'h0, 16'h0, 1'b0, NO_RESULT},
    '{ACT_EXEC, {OP_LD, 3'd6, 9'h0FE}, 16'h0, 16'h0, 1'b0, NO_RESULT},
    '{ACT_EXEC, {OP_LEA, 3'd0, 9'h100}, 16'h0, 16'h0, 1'b0, NO_RESULT},
    '{ACT_SETPC, 16'h0000, 16'h0000, 16'hFF00, 1'b0, NO_RESULT},
    // LDI through the top word to word zero, LDR with negative offset
    '{ACT_EXEC, {OP_LDI, 3'd2, 9'h0FE}, 16'h0, 16'h0, 1'b0, NO_RESULT},
    '{ACT_EXEC, {OP_LDR, 3'd3, 3'd0, 6'h3D}, 16'h0, 16'h0, 1'b0, NO_RESULT},
    // JSR min offset, JSRR through R7 itself, JMP, RET
    '{ACT_EXEC, {OP_JSR, 1'b1, 11'h400}, 16'h0, 16'h0, 1'b0, NO_RESULT},
    '{ACT_EXEC, {OP_JSR, 3'b000, LINK_REG, 6'h00}, 16'h0, 16'h0, 1'b0, NO_RESULT},
    '{ACT_EXEC, {OP_JMP, 3'd0, 3'd5, 6'h00}, 16'h0, 16'h0, 1'b0, NO_RESULT},
    '{ACT_EXEC, {OP_JMP, 3'd0, LINK_REG, 6'h00}, 16'h0, 16'h0, 1'b0, NO_RESULT},
    // unimplemented opcodes: PC step only
    '{ACT_EXEC, {OP_BR, 12'hFFF}, 16'h0, 16'h0, 1'b0, NO_RESULT},
    '{ACT_EXEC, {OP_STI, 12'hFFF}, 16'h0, 16'h0, 1'b0, NO_RESULT},
    '{ACT_EXEC, {OP_TRAP, 12'h025}, 16'h0, 16'h0, 1'b0, NO_RESULT},
    '{ACT_EXEC, {OP_RSV, 12'h000}, 16'h0, 16'h0, 1'b0, NO_RESULT}
  };

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;   // instruction[15:0], load_address[31:16], load_data[47:32]
  logic [1:0]  in_tuser   = '0;   // action[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;         // pc, cc, reg_index, reg_value, mem_address, mem_value
  logic [1:0]  out_tuser;         // reg_written[0], mem_written[1]

  // architectural state as the block should hold it
  logic [15:0] gpr [8];
  logic [15:0] pc_reg;
  logic [1:0]  cc_reg;
  logic [15:0] mem_img [int];     // only words written so far

  result_t result_q [$];          // predicted result words, oldest first

  int in_idle_pct;
  int out_idle_pct;
  int items_sent;
  int results_checked = 0;
  int mismatches      = 0;
  int cycles          = 0;
  int act_count [4];
  logic [15:0] op_seen;

  lc3_instruction_execute #(
    .ADDR_BITS(ADDR_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [1:0] flag_of(input logic [15:0] v);
    if (v == 16'h0000) return CC_ZERO;
    if (v[15]) return CC_NEG;
    return CC_POS;
  endfunction

  function automatic logic [15:0] mem_word(input logic [15:0] a);
    int k;
    k = int'(a & ADDR_MASK);
    return mem_img.exists(k) ? mem_img[k] : 16'h0000;
  endfunction

  // Executes one word against the bench copy of the state and returns the
  // result word the block must produce for it.
  task automatic execute_word(input logic [1:0] act, input logic [15:0] ins,
                              input logic [15:0] laddr, input logic [15:0] ldata,
                              output result_t r);
    logic [3:0]  op;
    logic [2:0]  dr;
    logic [2:0]  sr;
    logic [15:0] npc;
    logic [15:0] opnd;
    logic [15:0] off9;
    logic [15:0] dest;
    r = '0;
    case (act)
      ACT_LOAD:  mem_img[int'(laddr & ADDR_MASK)] = ldata;
      ACT_SETPC: pc_reg = ldata;
      ACT_EXEC: begin
        op   = ins[15:12];
        dr   = ins[11:9];
        sr   = ins[8:6];
        off9 = {{7{ins[8]}}, ins[8:0]};
        pc_reg = pc_reg + 16'd1;    // offsets below are relative to the bumped PC
        npc    = pc_reg;
        case (op)
          OP_ADD, OP_AND: begin
            opnd   = ins[5] ? {{11{ins[4]}}, ins[4:0]} : gpr[ins[2:0]];
            r.rval = (op == OP_ADD) ? gpr[sr] + opnd : gpr[sr] & opnd;
            r.rw   = 1'b1;
            r.ridx = dr;
          end
          OP_NOT: begin
            r.rval = ~gpr[sr];
            r.rw   = 1'b1;
            r.ridx = dr;
          end
          OP_LD: begin
            r.rval = mem_word(npc + off9);
            r.rw   = 1'b1;
            r.ridx = dr;
          end
          OP_LDI: begin
            r.rval = mem_word(mem_word(npc + off9));
            r.rw   = 1'b1;
            r.ridx = dr;
          end
          OP_LDR: begin
            r.rval = mem_word(gpr[sr] + {{10{ins[5]}}, ins[5:0]});
            r.rw   = 1'b1;
            r.ridx = dr;
          end
          OP_LEA: begin
            r.rval = npc + off9;
            r.rw   = 1'b1;
            r.ridx = dr;
          end
          OP_ST: begin
            // store only: registers and flags stay
            r.maddr = (npc + off9) & ADDR_MASK;
            r.mval  = gpr[dr];
            r.mw    = 1'b1;
            mem_img[int'(r.maddr)] = r.mval;
          end
          OP_JMP: pc_reg = gpr[sr];
          OP_JSR: begin
            // base read before the link write, so JSRR R7 jumps to old R7
            dest = ins[11] ? npc + {{5{ins[10]}}, ins[10:0]} : gpr[sr];
            gpr[LINK_REG] = npc;
            pc_reg = dest;
            r.rw   = 1'b1;
            r.ridx = LINK_REG;
            r.rval = npc;
          end
          default: ;
        endcase
        // JSR writes the link register without touching the flags
        if (r.rw && op != OP_JSR) begin
          gpr[r.ridx] = r.rval;
          cc_reg = flag_of(r.rval);
        end
      end
      default: ;
    endcase
    r.pc = pc_reg;
    r.cc = cc_reg;
  endtask

  // Presents one word, waits for the handshake, then predicts its result.
  // Leaves in_tvalid high; the next call or the drain lowers it.
  task automatic send_word(input logic [1:0] act, input logic [15:0] ins,
                           input logic [15:0] laddr, input logic [15:0] ldata,
                           input logic typed, input result_t typed_res);
    result_t r;
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {ldata, laddr, ins};
    do @(posedge clk); while (!in_tready);
    execute_word(act, ins, laddr, ldata, r);
    result_q.push_back(typed ? typed_res : r);
    items_sent++;
    act_count[act]++;
    if (act == ACT_EXEC) op_seen[ins[15:12]] = 1'b1;
  endtask

  // Memory reads must only hit written words: load one first if needed.
  task automatic make_readable(input logic [15:0] a);
    if (!mem_img.exists(int'(a & ADDR_MASK))) begin
      send_word(ACT_LOAD, 16'($urandom), a, 16'($urandom), 1'b0, NO_RESULT);
    end
  endtask

  task automatic random_word();
    logic [15:0] ins;
    logic [15:0] ea;
    int pick;
    pick = $urandom_range(99);
    ins  = 16'($urandom);
    if (pick < 4) begin
      // load close to the PC so later LD/LDI/ST traffic reuses it
      send_word(ACT_LOAD, ins, pc_reg + 16'($urandom_range(511)) - 16'd255,
                16'($urandom), 1'b0, NO_RESULT);
    end else if (pick < 9) begin
      send_word(ACT_LOAD, ins, 16'($urandom), 16'($urandom), 1'b0, NO_RESULT);
    end else if (pick < 14) begin
      send_word(ACT_SETPC, ins, 16'($urandom), 16'($urandom), 1'b0, NO_RESULT);
    end else if (pick < 16) begin
      send_word(ACT_NONE, ins, 16'($urandom), 16'($urandom), 1'b0, NO_RESULT);
    end else begin
      // mostly implemented opcodes, the rest fully random words
      if ($urandom_range(3) != 0) ins[15:12] = LIVE_OPS[$urandom_range(9)];
      case (ins[15:12])
        OP_LD:  make_readable(pc_reg + 16'd1 + {{7{ins[8]}}, ins[8:0]});
        OP_LDI: begin
          ea = pc_reg + 16'd1 + {{7{ins[8]}}, ins[8:0]};
          make_readable(ea);
          make_readable(mem_word(ea));
        end
        OP_LDR: make_readable(gpr[ins[8:6]] + {{10{ins[5]}}, ins[5:0]});
        default: ;
      endcase
      send_word(ACT_EXEC, ins, 16'($urandom), 16'($urandom), 1'b0, NO_RESULT);
    end
  endtask

  // Sender holds off until every predicted result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (result_q.size() != 0);
  endtask

  function automatic bit field_ok(input string name, input logic [15:0] want,
                                  input logic [15:0] seen);
    if (want !== seen) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, seen);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Result side: check on the handshake, then pick the next ready level.
  always @(posedge clk) begin
    result_t seen_res;
    result_t want_res;
    bit all_ok;
    if (rst_n && out_tvalid && out_tready) begin
      seen_res = {out_tdata[15:0], out_tdata[17:16], out_tuser[0], out_tdata[20:18],
                  out_tdata[36:21], out_tuser[1], out_tdata[52:37], out_tdata[68:53]};
      if (result_q.size() == 0) begin
        $display("%0t ns: result word with nothing outstanding, expected none, actual pc %h",
                 $time, seen_res.pc);
        mismatches++;
      end else begin
        want_res = result_q.pop_front();
        all_ok = field_ok("pc_now", want_res.pc, seen_res.pc);
        all_ok &= field_ok("cond_code", 16'(want_res.cc), 16'(seen_res.cc));
        all_ok &= field_ok("reg_written", 16'(want_res.rw), 16'(seen_res.rw));
        all_ok &= field_ok("reg_index", 16'(want_res.ridx), 16'(seen_res.ridx));
        all_ok &= field_ok("reg_value", want_res.rval, seen_res.rval);
        all_ok &= field_ok("mem_written", 16'(want_res.mw), 16'(seen_res.mw));
        all_ok &= field_ok("mem_address", want_res.maddr, seen_res.maddr);
        all_ok &= field_ok("mem_value", want_res.mval, seen_res.mval);
        if (!all_ok) mismatches++;
        results_checked++;
      end
    end
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, result_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    items_sent      = 0;
    op_seen         = '0;
    act_count       = '{default: 0};
    // reset image of the block
    foreach (gpr[i]) gpr[i] = 16'h0000;
    pc_reg = 16'h0000;
    cc_reg = CC_ZERO;
    mem_img.delete();

    // phase 1: sender idles lightly, receiver stalls heavily
    in_idle_pct  = 32;
    out_idle_pct = 74;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_word(DIRECTED[i].act, DIRECTED[i].ins, DIRECTED[i].laddr, DIRECTED[i].ldata,
                DIRECTED[i].typed, DIRECTED[i].exp);
    end
    while (items_sent < 200) random_word();
    drain_results();

    // phase 2: roles swapped
    in_idle_pct  = 74;
    out_idle_pct = 32;
    while (items_sent < 400) random_word();
    drain_results();

    // phase 3: back-to-back on both sides
    in_idle_pct  = 0;
    out_idle_pct = 0;
    while (items_sent < 600) random_word();
    drain_results();

    // longest path is LDR/LDI (DEC, EX, MEM); leave room for any stray word
    repeat (8) @(posedge clk);

    $display("Run: %0d words in (%0d execute, %0d memory load, %0d PC set, %0d unused action)",
             items_sent, act_count[ACT_EXEC], act_count[ACT_LOAD], act_count[ACT_SETPC],
             act_count[ACT_NONE]);
    $display("Run: %0d result words compared, %0d of 16 opcodes executed, %0d cycles",
             results_checked, $countones(op_seen), cycles);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
